### src/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared field widths, register map codes and item codes for the bilinear
// image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Field widths of the request and result channels
  localparam int MODE_W  = 1;
  localparam int LOAD_W  = 8;
  localparam int COORD_W = 10;
  localparam int PIX_W   = 8;

  // Configuration register widths
  localparam int STEP_W  = 24;
  localparam int SIZE_W  = 9;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // Scale step is unsigned Q8.16
  localparam int STEP_FRAC_BITS = 16;

  // Register map (index = byte address / 4)
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_STEP  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_SIZE = 1'b1;

  // Register reset values
  localparam logic [STEP_W-1:0] SCALE_STEP_RST  = 24'd65536;
  localparam logic [SIZE_W-1:0] SOURCE_SIZE_RST = 9'd256;

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_LOAD    = 1'b0;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 1'b1;

endpackage

### src/bis_axis.sv
// ----------------------------------------------------------------------------
// bis_axis
// One axis of the source position: coordinate times step, then base index,
// clamped neighbor index and fraction. Two register stages.
// ----------------------------------------------------------------------------
module bis_axis #(
  parameter int MAX_SOURCE    = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                   clk,
  input  logic [bis_pkg::COORD_W-1:0]            coord,
  input  logic [bis_pkg::STEP_W-1:0]             step,
  input  logic [$clog2(MAX_SOURCE+1)-1:0]        size_eff,
  output logic [$clog2(MAX_SOURCE)-1:0]          base_r,
  output logic [$clog2(MAX_SOURCE)-1:0]          next_r,
  output logic [FRACTION_BITS-1:0]               frac_r,
  output logic                                   clip_r
);
  import bis_pkg::*;

  localparam int IDXW = $clog2(MAX_SOURCE);
  localparam int SZW  = $clog2(MAX_SOURCE + 1);
  localparam int PW   = COORD_W + STEP_W;
  localparam int IPW  = PW - STEP_FRAC_BITS;

  logic [PW-1:0]            pos_r;
  logic [IPW-1:0]           ipart;
  logic [SZW-1:0]           size_m1;
  logic [IDXW-1:0]          last;
  logic                     clip_nxt;
  logic [IDXW-1:0]          base_nxt;
  logic [IDXW-1:0]          next_nxt;
  logic [FRACTION_BITS-1:0] frac_nxt;

  // Stage 1: exact source position
  always_ff @(posedge clk) begin
    pos_r <= PW'(coord) * PW'(step);
  end

  // Stage 2: clamp base to the image, clamp neighbor to the edge
  always_comb begin
    ipart    = pos_r[PW-1:STEP_FRAC_BITS];
    size_m1  = size_eff - SZW'(1);
    last     = size_m1[IDXW-1:0];
    clip_nxt = (ipart >= IPW'(size_eff));
    base_nxt = clip_nxt ? last : ipart[IDXW-1:0];
    if (!clip_nxt && (ipart < IPW'(size_m1))) begin
      next_nxt = IDXW'(ipart[IDXW-1:0] + IDXW'(1));
    end else begin
      next_nxt = last;
    end
    frac_nxt = clip_nxt ? '0 : pos_r[STEP_FRAC_BITS-1 -: FRACTION_BITS];
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    next_r <= next_nxt;
    frac_r <= frac_nxt;
    clip_r <= clip_nxt;
  end

endmodule

### src/bilinear_image_scaler_top.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_top
// A compute's result passes position, clamp, bank read, weighting, sum stages.
// Throughput: one request per cycle, loads and computes mixed; busy stays low.
// The four neighbors come from four row/column parity banks, one read each.
// Reset clears config registers and pipeline valids; the image is not cleared.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_top #(
  parameter int MAX_SOURCE    = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [bis_pkg::MODE_W-1:0]    in_mode,
  input  logic [bis_pkg::LOAD_W-1:0]    in_load_row,
  input  logic [bis_pkg::LOAD_W-1:0]    in_load_col,
  input  logic [bis_pkg::PIX_W-1:0]     in_load_pixel,
  input  logic [bis_pkg::COORD_W-1:0]   in_out_x,
  input  logic [bis_pkg::COORD_W-1:0]   in_out_y,
  // result channel
  output logic                          out_strobe,
  output logic [bis_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_clamped,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bis_pkg::APB_AW-1:0]    paddr,
  input  logic [bis_pkg::APB_DW-1:0]    pwdata,
  output logic [bis_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import bis_pkg::*;

  localparam int IDXW = $clog2(MAX_SOURCE);
  localparam int SZW  = $clog2(MAX_SOURCE + 1);
  localparam int HW   = (IDXW > 1) ? IDXW - 1 : 1;
  localparam int AW   = 2 * HW;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int FB   = FRACTION_BITS;
  localparam int GW   = FB + 1;
  localparam int WW   = 2 * FB + 1;
  localparam int PRW  = WW + PIX_W;
  localparam int SW   = PRW + 2;
  localparam int EXTW = 12;
  localparam logic [GW-1:0] ONE = GW'(1) << FB;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0]    cfg_step_r;
  logic [SIZE_W-1:0]    cfg_size_r;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2 +: REG_IDX_W];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_step_r <= SCALE_STEP_RST;
      cfg_size_r <= SOURCE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SCALE_STEP:  cfg_step_r <= pwdata[STEP_W-1:0];
        REG_SOURCE_SIZE: cfg_size_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SCALE_STEP:  prdata = APB_DW'(cfg_step_r);
      REG_SOURCE_SIZE: prdata = APB_DW'(cfg_size_r);
      default:         prdata = '0;
    endcase
  end

  // Effective image size: zero reads as one, capped at the store size
  logic [EXTW-1:0] size_ext;
  logic [SZW-1:0]  size_eff;

  always_comb begin
    size_ext = EXTW'(cfg_size_r);
    if (size_ext == '0) begin
      size_eff = SZW'(1);
    end else if (size_ext > EXTW'(MAX_SOURCE)) begin
      size_eff = SZW'(MAX_SOURCE);
    end else begin
      size_eff = size_ext[SZW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Request accept and load path (stages 1-2)
  // --------------------------------------------------------------------------
  logic            accept;
  logic            cmp_v1_r, cmp_v2_r, cmp_v3_r, cmp_v4_r;
  logic            ld_v1_r, ld_v2_r;
  logic            ld_v1_nxt;
  logic [EXTW-1:0] ld_row_ext, ld_col_ext;
  logic [IDXW-1:0] ld_row1_r, ld_col1_r, ld_row2_r, ld_col2_r;
  logic [PIX_W-1:0] ld_pix1_r, ld_pix2_r;

  assign busy       = 1'b0;
  assign accept     = start & ~busy;
  assign ld_row_ext = EXTW'(in_load_row);
  assign ld_col_ext = EXTW'(in_load_col);
  // loads outside the store are dropped
  assign ld_v1_nxt  = accept & (in_mode == MODE_LOAD) &
                      (ld_row_ext < EXTW'(MAX_SOURCE)) & (ld_col_ext < EXTW'(MAX_SOURCE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v1_r <= 1'b0;
      cmp_v2_r <= 1'b0;
      cmp_v3_r <= 1'b0;
      cmp_v4_r <= 1'b0;
      ld_v1_r  <= 1'b0;
      ld_v2_r  <= 1'b0;
    end else begin
      cmp_v1_r <= accept & (in_mode == MODE_COMPUTE);
      cmp_v2_r <= cmp_v1_r;
      cmp_v3_r <= cmp_v2_r;
      cmp_v4_r <= cmp_v3_r;
      ld_v1_r  <= ld_v1_nxt;
      ld_v2_r  <= ld_v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ld_row1_r <= ld_row_ext[IDXW-1:0];
    ld_col1_r <= ld_col_ext[IDXW-1:0];
    ld_pix1_r <= in_load_pixel;
    ld_row2_r <= ld_row1_r;
    ld_col2_r <= ld_col1_r;
    ld_pix2_r <= ld_pix1_r;
  end

  // --------------------------------------------------------------------------
  // Source position per axis (stages 1-2)
  // --------------------------------------------------------------------------
  logic [IDXW-1:0] c0, c1, r0, r1;
  logic [FB-1:0]   fx, fy;
  logic            clip_x, clip_y;

  bis_axis #(
    .MAX_SOURCE    (MAX_SOURCE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis_x (
    .clk      (clk),
    .coord    (in_out_x),
    .step     (cfg_step_r),
    .size_eff (size_eff),
    .base_r   (c0),
    .next_r   (c1),
    .frac_r   (fx),
    .clip_r   (clip_x)
  );

  bis_axis #(
    .MAX_SOURCE    (MAX_SOURCE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis_y (
    .clk      (clk),
    .coord    (in_out_y),
    .step     (cfg_step_r),
    .size_eff (size_eff),
    .base_r   (r0),
    .next_r   (r1),
    .frac_r   (fy),
    .clip_r   (clip_y)
  );

  // --------------------------------------------------------------------------
  // Stage 3: parity banks (write for loads, read for computes) and weights
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] rd_q_r [4];
  logic [IDXW-1:0]  ld_row_half, ld_col_half;
  logic [AW-1:0]    wr_addr;

  assign ld_row_half = ld_row2_r >> 1;
  assign ld_col_half = ld_col2_r >> 1;
  assign wr_addr     = {HW'(ld_row_half), HW'(ld_col_half)};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic ROW_PAR = 1'((b >> 1) & 1);
    localparam logic COL_PAR = 1'(b & 1);

    logic [PIX_W-1:0] mem [BANK_DEPTH];
    logic [IDXW-1:0]  rsel, csel, rsel_half, csel_half;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;

    // each bank serves whichever neighbor row/column has its parity
    assign rsel      = (r0[0] == ROW_PAR) ? r0 : r1;
    assign csel      = (c0[0] == COL_PAR) ? c0 : c1;
    assign rsel_half = rsel >> 1;
    assign csel_half = csel >> 1;
    assign rd_addr   = {HW'(rsel_half), HW'(csel_half)};
    assign wr_en     = ld_v2_r & (ld_row2_r[0] == ROW_PAR) & (ld_col2_r[0] == COL_PAR);

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= ld_pix2_r;
      end
      rd_q_r[b] <= mem[rd_addr];
    end
  end

  logic [GW-1:0] gx, gy;
  logic [WW-1:0] w1_r, w2_r, w3_r, w4_r;
  logic          r0p_r, r1p_r, c0p_r, c1p_r, clip3_r;

  assign gx = ONE - GW'(fx);
  assign gy = ONE - GW'(fy);

  // products are formed at the full weight width
  always_ff @(posedge clk) begin
    w1_r    <= WW'(gx) * WW'(gy);
    w2_r    <= WW'(fx) * WW'(gy);
    w3_r    <= WW'(gx) * WW'(fy);
    w4_r    <= WW'(fx) * WW'(fy);
    r0p_r   <= r0[0];
    r1p_r   <= r1[0];
    c0p_r   <= c0[0];
    c1p_r   <= c1[0];
    clip3_r <= clip_x | clip_y;
  end

  // --------------------------------------------------------------------------
  // Stage 4: route bank data to neighbors, weight each pixel
  // --------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] pick(input logic rp, input logic cp,
                                            input logic [PIX_W-1:0] q00,
                                            input logic [PIX_W-1:0] q01,
                                            input logic [PIX_W-1:0] q10,
                                            input logic [PIX_W-1:0] q11);
    logic [PIX_W-1:0] res;
    case ({rp, cp})
      2'b00:   res = q00;
      2'b01:   res = q01;
      2'b10:   res = q10;
      default: res = q11;
    endcase
    return res;
  endfunction

  logic [PIX_W-1:0] p1, p2, p3, p4;
  logic [PRW-1:0]   m1_r, m2_r, m3_r, m4_r;
  logic             clip4_r;

  assign p1 = pick(r0p_r, c0p_r, rd_q_r[0], rd_q_r[1], rd_q_r[2], rd_q_r[3]);
  assign p2 = pick(r0p_r, c1p_r, rd_q_r[0], rd_q_r[1], rd_q_r[2], rd_q_r[3]);
  assign p3 = pick(r1p_r, c0p_r, rd_q_r[0], rd_q_r[1], rd_q_r[2], rd_q_r[3]);
  assign p4 = pick(r1p_r, c1p_r, rd_q_r[0], rd_q_r[1], rd_q_r[2], rd_q_r[3]);

  always_ff @(posedge clk) begin
    m1_r    <= PRW'(w1_r) * PRW'(p1);
    m2_r    <= PRW'(w2_r) * PRW'(p2);
    m3_r    <= PRW'(w3_r) * PRW'(p3);
    m4_r    <= PRW'(w4_r) * PRW'(p4);
    clip4_r <= clip3_r;
  end

  // --------------------------------------------------------------------------
  // Stage 5: sum, truncate, result register
  // --------------------------------------------------------------------------
  logic [SW-1:0]    sum;
  logic             out_strobe_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_clamped_r;

  assign sum = SW'(m1_r) + SW'(m2_r) + SW'(m3_r) + SW'(m4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmp_v4_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r   <= sum[2*FB +: PIX_W];
    out_clamped_r <= clip4_r;
  end

  assign out_strobe  = out_strobe_r;
  assign out_pixel   = out_pixel_r;
  assign out_clamped = out_clamped_r;

endmodule

### verif/bilinear_image_scaler_top_test.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_top_test
// Self-checking bench for the bilinear image scaler. A stimulus table covers
// edge clamping, zero and extreme steps and odd source sizes. Randomized
// phases then drive random loads and computes under several register
// settings. Every compute request first loads any neighbor pixel it would
// read that is still unwritten. An in-bench scaler model predicts each pixel
// the table does not spell out; strobed results are checked oldest first.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_top_test;
  import bis_pkg::*;

  localparam int MAX_SRC        = 256;
  localparam int FRAC_BITS      = 8;
  localparam int ONE            = 1 << FRAC_BITS;
  localparam int RESULT_LATENCY = 5;
  localparam int PHASES         = 12;
  localparam int PHASE_REQS     = 95;
  localparam int POS_W          = COORD_W + STEP_W;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LOAD_W-1:0]  row;
    logic [LOAD_W-1:0]  col;
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } scaler_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             clamped;
  } scaler_res_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [APB_DW-1:0]     reg_val;
    scaler_req_t           req;
    logic                  typed;
    scaler_res_t           res;
  } stim_row_t;

  // Clock, reset and block ports
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   in_mode = MODE_LOAD;
  logic [LOAD_W-1:0]   in_load_row = '0;
  logic [LOAD_W-1:0]   in_load_col = '0;
  logic [PIX_W-1:0]    in_load_pixel = '0;
  logic [COORD_W-1:0]  in_out_x = '0;
  logic [COORD_W-1:0]  in_out_y = '0;
  logic                out_strobe;
  logic [PIX_W-1:0]    out_pixel;
  logic                out_clamped;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Scaler model state
  logic [PIX_W-1:0]    src_img [0:MAX_SRC*MAX_SRC-1];
  bit                  src_written [0:MAX_SRC*MAX_SRC-1];
  logic [STEP_W-1:0]   cur_step = SCALE_STEP_RST;
  logic [SIZE_W-1:0]   cur_size = SOURCE_SIZE_RST;

  scaler_res_t         pending_pixels [$];
  stim_row_t           dir_tbl [$];
  int unsigned         fail_cnt = 0;
  int unsigned         req_cnt = 0;
  int unsigned         idle_pct = 0;

  bilinear_image_scaler_top #(
    .MAX_SOURCE(MAX_SRC),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_load_row(in_load_row), .in_load_col(in_load_col),
    .in_load_pixel(in_load_pixel), .in_out_x(in_out_x), .in_out_y(in_out_y),
    .out_strobe(out_strobe), .out_pixel(out_pixel), .out_clamped(out_clamped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  initial begin
    #1600000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scaler model
  // ---------------------------------------------------------------------------

  // Size register 0 acts as 1, anything above the store acts as the store size
  function automatic int unsigned eff_size();
    if (cur_size == 0) return 1;
    if (cur_size > MAX_SRC) return MAX_SRC;
    return 32'(cur_size);
  endfunction

  // One axis: base index, second neighbor, fraction; returns the clamp flag
  function automatic bit resolve_axis(input logic [COORD_W-1:0] coord,
                                      input int unsigned n,
                                      output int unsigned base,
                                      output int unsigned nxt,
                                      output int unsigned frac);
    logic [POS_W-1:0] pos;
    int unsigned ipart;
    bit clip;
    pos   = POS_W'(coord) * POS_W'(cur_step);
    ipart = 32'(pos[POS_W-1:STEP_FRAC_BITS]);
    frac  = 32'(pos[STEP_FRAC_BITS-1:0]) >> (STEP_FRAC_BITS - FRAC_BITS);
    clip  = 1'b0;
    if (ipart >= n) begin
      ipart = n - 1;
      frac  = 0;
      clip  = 1'b1;
    end
    base = ipart;
    nxt  = (base + 1 < n) ? base + 1 : n - 1;
    return clip;
  endfunction

  function automatic scaler_res_t scale_pixel(logic [COORD_W-1:0] x,
                                              logic [COORD_W-1:0] y);
    int unsigned n, c0, c1, r0, r1, fx, fy, gx, gy, sum;
    bit clip_x, clip_y;
    scaler_res_t res;
    n      = eff_size();
    clip_x = resolve_axis(x, n, c0, c1, fx);
    clip_y = resolve_axis(y, n, r0, r1, fy);
    gx  = ONE - fx;
    gy  = ONE - fy;
    sum = gx * gy * src_img[r0*MAX_SRC + c0] + fx * gy * src_img[r0*MAX_SRC + c1]
        + gx * fy * src_img[r1*MAX_SRC + c0] + fx * fy * src_img[r1*MAX_SRC + c1];
    res.pixel   = PIX_W'(sum >> (2 * FRAC_BITS));
    res.clamped = clip_x | clip_y;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  function automatic scaler_req_t make_load(int unsigned r, int unsigned c, int unsigned p);
    scaler_req_t q;
    q       = '0;
    q.mode  = MODE_LOAD;
    q.row   = LOAD_W'(r);
    q.col   = LOAD_W'(c);
    q.pixel = PIX_W'(p);
    q.x     = COORD_W'($urandom_range(1023));
    q.y     = COORD_W'($urandom_range(1023));
    return q;
  endfunction

  function automatic scaler_req_t make_compute(int unsigned x, int unsigned y);
    scaler_req_t q;
    q       = '0;
    q.mode  = MODE_COMPUTE;
    q.row   = LOAD_W'($urandom_range(255));
    q.col   = LOAD_W'($urandom_range(255));
    q.pixel = PIX_W'($urandom_range(255));
    q.x     = COORD_W'(x);
    q.y     = COORD_W'(y);
    return q;
  endfunction

  function automatic stim_row_t ld(int unsigned r, int unsigned c, int unsigned p);
    stim_row_t s;
    s      = '0;
    s.kind = ROW_REQ;
    s.req  = make_load(r, c, p);
    return s;
  endfunction

  function automatic stim_row_t cmp(int unsigned x, int unsigned y);
    stim_row_t s;
    s      = '0;
    s.kind = ROW_REQ;
    s.req  = make_compute(x, y);
    return s;
  endfunction

  // Compute row with its result written out by hand
  function automatic stim_row_t cmp_exp(int unsigned x, int unsigned y,
                                        int unsigned p, bit clamp);
    stim_row_t s;
    s             = cmp(x, y);
    s.typed       = 1'b1;
    s.res.pixel   = PIX_W'(p);
    s.res.clamped = clamp;
    return s;
  endfunction

  function automatic stim_row_t set_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
    stim_row_t s;
    s         = '0;
    s.kind    = ROW_REG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic int unsigned rand_pixel();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Mostly coordinates that land on or just past the image
  function automatic int unsigned pick_coord();
    int unsigned reach;
    if (cur_step == 0 || $urandom_range(4) == 0) return $urandom_range(1023);
    reach = ((eff_size() + 1) << STEP_FRAC_BITS) / 32'(cur_step) + 1;
    if (reach > 1023) reach = 1023;
    return $urandom_range(reach);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic idle_burst(int unsigned cycles);
    start         <= 1'b0;
    in_mode       <= MODE_W'($urandom_range(1));
    in_load_row   <= LOAD_W'($urandom_range(255));
    in_load_col   <= LOAD_W'($urandom_range(255));
    in_load_pixel <= PIX_W'($urandom_range(255));
    in_out_x      <= COORD_W'($urandom_range(1023));
    in_out_y      <= COORD_W'($urandom_range(1023));
    repeat (cycles) @(posedge clk);
  endtask

  // Present one request, hold it until taken, then update the model
  task automatic drive_request(scaler_req_t q, bit typed, scaler_res_t typed_res);
    start         <= 1'b1;
    in_mode       <= q.mode;
    in_load_row   <= q.row;
    in_load_col   <= q.col;
    in_load_pixel <= q.pixel;
    in_out_x      <= q.x;
    in_out_y      <= q.y;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    req_cnt++;
    if (q.mode == MODE_LOAD) begin
      src_img[{q.row, q.col}]     = q.pixel;
      src_written[{q.row, q.col}] = 1'b1;
    end else begin
      pending_pixels.push_back(typed ? typed_res : scale_pixel(q.x, q.y));
    end
    if ($urandom_range(99) < idle_pct) idle_burst($urandom_range(1, 4));
  endtask

  // Make sure every pixel a compute will read has been loaded
  task automatic load_neighbors(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int unsigned n, f, addr;
    int unsigned rows [2];
    int unsigned cols [2];
    n = eff_size();
    void'(resolve_axis(x, n, cols[0], cols[1], f));
    void'(resolve_axis(y, n, rows[0], rows[1], f));
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        addr = rows[i] * MAX_SRC + cols[j];
        if (!src_written[addr])
          drive_request(make_load(rows[i], cols[j], rand_pixel()), 1'b0, '0);
      end
    end
  endtask

  // Let all outstanding work leave the pipeline
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    while (pending_pixels.size() != 0 && guard < 500) begin
      @(posedge clk);
      guard++;
    end
    repeat (RESULT_LATENCY + 3) @(posedge clk);
  endtask

  // Register write in a setup phase and an access phase, then idle; the model copy follows
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SCALE_STEP:  cur_step = val[STEP_W-1:0];
      REG_SOURCE_SIZE: cur_size = val[SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    scaler_res_t want;
    if (rst_n && out_strobe) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: out_pixel %0d out_clamped %0d", out_pixel, out_clamped);
        fail_cnt++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want.pixel) begin
          $error("out_pixel: expected %0d, actual %0d", want.pixel, out_pixel);
          fail_cnt++;
        end
        if (out_clamped !== want.clamped) begin
          $error("out_clamped: expected %0d, actual %0d", want.clamped, out_clamped);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    scaler_req_t q;
    int unsigned phase_end, n;
    logic [STEP_W-1:0] step_sel;
    logic [SIZE_W-1:0] size_sel;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, starting from the reset register values
    dir_tbl.push_back(ld(0, 0, 255));
    dir_tbl.push_back(ld(0, 1, 0));
    dir_tbl.push_back(ld(1, 0, 0));
    dir_tbl.push_back(ld(1, 1, 0));
    dir_tbl.push_back(cmp_exp(0, 0, 255, 0));
    dir_tbl.push_back(ld(255, 255, 170));
    dir_tbl.push_back(cmp_exp(1023, 1023, 170, 1));   // base past the image
    dir_tbl.push_back(cmp_exp(255, 255, 170, 0));     // neighbor past the edge only
    dir_tbl.push_back(set_reg(REG_SCALE_STEP, 24'h008000));
    dir_tbl.push_back(cmp(1, 0));
    dir_tbl.push_back(cmp(1, 1));
    dir_tbl.push_back(ld(0, 1, 128));                 // load right before its reader
    dir_tbl.push_back(cmp(1, 1));
    dir_tbl.push_back(set_reg(REG_SCALE_STEP, 0));   // zero step
    dir_tbl.push_back(cmp_exp(1023, 517, 255, 0));
    dir_tbl.push_back(set_reg(REG_SCALE_STEP, 24'hFFFFFF));
    dir_tbl.push_back(cmp_exp(1, 1, 170, 0));
    dir_tbl.push_back(cmp_exp(2, 2, 170, 1));
    dir_tbl.push_back(set_reg(REG_SOURCE_SIZE, 1));
    dir_tbl.push_back(cmp_exp(5, 3, 255, 1));
    dir_tbl.push_back(set_reg(REG_SOURCE_SIZE, 0));  // size zero acts as one
    dir_tbl.push_back(cmp_exp(0, 0, 255, 0));
    dir_tbl.push_back(set_reg(REG_SOURCE_SIZE, 511)); // size above the store
    dir_tbl.push_back(cmp_exp(2, 2, 170, 1));

    idle_pct = 20;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_REG) begin
        drain_results();
        write_reg(dir_tbl[i].reg_idx, dir_tbl[i].reg_val);
      end else begin
        if (dir_tbl[i].req.mode == MODE_COMPUTE)
          load_neighbors(dir_tbl[i].req.x, dir_tbl[i].req.y);
        drive_request(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].res);
      end
    end

    // Random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:  begin step_sel = SCALE_STEP_RST; size_sel = SOURCE_SIZE_RST; end
        1:  begin step_sel = 24'h00C000;     size_sel = 9'd64;  end
        2:  begin step_sel = 24'h018000;     size_sel = 9'd256; end
        3:  begin step_sel = 24'h000001;     size_sel = 9'd256; end
        4:  begin step_sel = 24'hFFFFFF;     size_sel = 9'd256; end
        5:  begin step_sel = 24'h004000;     size_sel = 9'd16;  end
        6:  begin step_sel = 24'h000000;     size_sel = 9'd2;   end
        7:  begin
          step_sel = STEP_W'($urandom_range(24'h001000, 24'h040000));
          size_sel = 9'd0;
        end
        8:  begin
          step_sel = STEP_W'($urandom_range(24'h001000, 24'h040000));
          size_sel = 9'd511;
        end
        9:  begin
          step_sel = STEP_W'($urandom_range(24'h001000, 24'h040000));
          size_sel = 9'd1;
        end
        10: begin
          step_sel = STEP_W'($urandom_range(24'h001000, 24'h040000));
          size_sel = SIZE_W'($urandom_range(1, 256));
        end
        default: begin step_sel = SCALE_STEP_RST; size_sel = 9'd32; end
      endcase
      drain_results();
      write_reg(REG_SCALE_STEP, APB_DW'(step_sel));
      write_reg(REG_SOURCE_SIZE, APB_DW'(size_sel));

      // Idle mix per phase is picked at random; the last phase runs back to back
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (p == PHASES - 1) idle_pct = 0;

      phase_end = req_cnt + PHASE_REQS;
      while (req_cnt < phase_end) begin
        n = eff_size();
        if ($urandom_range(99) < 25) begin
          if ($urandom_range(1))
            q = make_load($urandom_range(n - 1), $urandom_range(n - 1), rand_pixel());
          else
            q = make_load($urandom_range(255), $urandom_range(255), rand_pixel());
        end else begin
          q = make_compute(pick_coord(), pick_coord());
          load_neighbors(q.x, q.y);
        end
        drive_request(q, 1'b0, '0);
      end
    end

    drain_results();
    if (pending_pixels.size() != 0) begin
      $error("%0d expected results never arrived", pending_pixels.size());
      fail_cnt++;
    end
    if (fail_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
